// ----- rtl/ffa_pkg.sv -----
// Package for the first-fit free-list allocator.
// Holds field widths, the default heap size and the operation codes.
// No dependencies.
`default_nettype none

package ffa_pkg;

    localparam int HEAP_BYTES_DEF = 65536;
    localparam int SIZE_W         = 16;
    localparam int PTR_W          = 16;
    localparam int NEED_W         = SIZE_W - 2;
    localparam int HDR_BYTES      = 4;
    localparam int GRAN_PAD       = HDR_BYTES + 7;
    localparam int MIN_SPLIT_G    = 2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/first_fit_free_list_allocator.sv -----
// First-fit free-list heap allocator: top level with the list walker and the head register.
// Depends on ffa_pkg and ffa_ram (block size memory and next link memory).
//
//  channel  dir  tdata                          tuser
//  s_axis   in   [15:0] size, [31:16] ptr       [0] func (0 alloc, 1 free)
//  m_axis   out  [15:0] ptr_out                 [0] ok
//
// Free: the result is registered as the item is taken; one link memory write for a valid pointer.
// Alloc: the walker visits free blocks in list order, one header read through the registered
// memory port per visited block, plus a split step when a split tail is written back.
// A new item is taken only when the output register is empty and the walker idles.
// Reset needs no clearing pass: entry 0 reads as the whole heap until first written.
`default_nettype none

module first_fit_free_list_allocator #(
    parameter int HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // size[15:0], ptr[31:16]
    input  wire logic [0:0]  s_axis_tuser,  // func[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,  // ptr_out[15:0]
    output logic      [0:0]  m_axis_tuser   // ok[0]
);

    import ffa_pkg::*;

    localparam int GRANULES = HEAP_BYTES / 8;
    localparam int GW       = $clog2(GRANULES);
    localparam int SW       = $clog2(GRANULES + 1);
    localparam int LW       = GW + 1;
    localparam int CW       = ((SW > NEED_W) ? SW : NEED_W) + 2;
    localparam int PW       = ((GW + 3) > PTR_W) ? (GW + 3) : PTR_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_SPLIT = 2'd2;

    logic [1:0]        r_state;
    logic [GW-1:0]     r_head;
    logic              r_head_v;
    logic              r_size0_set;
    logic              r_link0_set;
    logic              r_rd_zero;
    logic [GW-1:0]     r_cur;
    logic [GW-1:0]     r_prev;
    logic              r_have_prev;
    logic [GW-1:0]     r_steps;
    logic [NEED_W-1:0] r_need;
    logic [GW-1:0]     r_tail;
    logic [SW-1:0]     r_rest;
    logic              r_out_valid;
    logic [PTR_W-1:0]  r_out_ptr;
    logic              r_out_ok;

    logic              in_fire;
    logic              in_func;
    logic [SIZE_W-1:0] in_size;
    logic [PTR_W-1:0]  in_ptr;
    logic [SIZE_W:0]   req;
    logic [SIZE_W:0]   req_sum;
    logic [NEED_W-1:0] need_in;

    logic [SW-1:0]     size_rdata;
    logic [LW-1:0]     link_rdata;
    logic [SW-1:0]     size_q;
    logic [LW-1:0]     link_q;
    logic [GW-1:0]     link_next;
    logic              link_v;

    logic              fit;
    logic [SW-1:0]     rest;
    logic [CW-1:0]     tail_w;
    logic              split;
    logic              walk_on;
    logic              head_ok;
    logic [PW-1:0]     ptr_wide;

    logic [PTR_W-4:0]  fr_g;
    logic              fr_valid;

    logic              size_we;
    logic [GW-1:0]     size_waddr;
    logic [SW-1:0]     size_wdata;
    logic              link_we;
    logic [GW-1:0]     link_waddr;
    logic [LW-1:0]     link_wdata;
    logic [GW-1:0]     raddr;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign in_func = s_axis_tuser[0];
    assign in_size = s_axis_tdata[SIZE_W-1:0];
    assign in_ptr  = s_axis_tdata[SIZE_W+PTR_W-1:SIZE_W];

    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_ptr;
    assign m_axis_tuser  = r_out_ok;

    always_comb begin
        req     = (in_size == '0) ? (SIZE_W+1)'(1) : {1'b0, in_size};
        req_sum = req + (SIZE_W+1)'(GRAN_PAD);
        need_in = req_sum[SIZE_W:3];
    end

    assign size_q    = (r_rd_zero && !r_size0_set) ? SW'(GRANULES) : size_rdata;
    assign link_q    = (r_rd_zero && !r_link0_set) ? '0 : link_rdata;
    assign link_next = link_q[GW-1:0];
    assign link_v    = link_q[GW];

    assign fit     = CW'(size_q) >= CW'(r_need);
    assign rest    = size_q - SW'(r_need);
    assign tail_w  = CW'(r_cur) + CW'(r_need);
    assign split   = (rest >= SW'(MIN_SPLIT_G)) && (tail_w < CW'(GRANULES));
    assign walk_on = link_v && (CW'(link_next) < CW'(GRANULES))
                     && (r_steps < GW'(GRANULES - 1));
    assign head_ok = r_head_v && (CW'(r_head) < CW'(GRANULES));
    assign ptr_wide = PW'({r_cur, 3'b100});

    assign fr_g     = in_ptr[PTR_W-1:3];
    assign fr_valid = (in_ptr[2:0] == 3'b100) && (CW'(fr_g) < CW'(GRANULES));

    always_comb begin
        size_we    = 1'b0;
        size_waddr = r_cur;
        size_wdata = SW'(r_need);
        link_we    = 1'b0;
        link_waddr = r_prev;
        link_wdata = link_q;
        raddr      = r_cur;
        unique case (r_state)
            ST_IDLE: begin
                raddr      = r_head;
                link_waddr = GW'(fr_g);
                link_wdata = {r_head_v, r_head};
                link_we    = in_fire && (in_func == FUNC_FREE) && fr_valid;
            end
            ST_WALK: begin
                raddr   = link_next;
                size_we = fit;
                link_we = fit && r_have_prev;
            end
            ST_SPLIT: begin
                size_we    = 1'b1;
                size_waddr = r_tail;
                size_wdata = r_rest;
                link_we    = 1'b1;
                link_waddr = r_tail;
                link_wdata = {r_head_v, r_head};
            end
            default: begin
                raddr = r_cur;
            end
        endcase
    end

    ffa_ram #(
        .WIDTH (SW),
        .DEPTH (GRANULES)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (size_waddr),
        .i_wdata (size_wdata),
        .i_raddr (raddr),
        .o_rdata (size_rdata)
    );

    ffa_ram #(
        .WIDTH (LW),
        .DEPTH (GRANULES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (raddr),
        .o_rdata (link_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_head_v    <= 1'b1;
            r_size0_set <= 1'b0;
            r_link0_set <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (size_we && (size_waddr == '0)) begin
                r_size0_set <= 1'b1;
            end
            if (link_we && (link_waddr == '0)) begin
                r_link0_set <= 1'b1;
            end
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (in_func == FUNC_FREE) begin
                            r_out_valid <= 1'b1;
                            if (fr_valid) begin
                                r_head   <= GW'(fr_g);
                                r_head_v <= 1'b1;
                            end
                        end else if (head_ok) begin
                            r_state <= ST_WALK;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                ST_WALK: begin
                    if (fit) begin
                        if (!r_have_prev) begin
                            r_head   <= link_next;
                            r_head_v <= link_v;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= split ? ST_SPLIT : ST_IDLE;
                    end else if (!walk_on) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_SPLIT: begin
                    r_head   <= r_tail;
                    r_head_v <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_zero <= (raddr == '0);
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_need      <= need_in;
                    r_cur       <= r_head;
                    r_have_prev <= 1'b0;
                    r_steps     <= '0;
                    r_out_ptr   <= '0;
                    if (in_func == FUNC_FREE) begin
                        r_out_ok <= (in_ptr == '0) || fr_valid;
                    end else begin
                        r_out_ok <= 1'b0;
                    end
                end
            end
            ST_WALK: begin
                if (fit) begin
                    r_out_ptr <= ptr_wide[PTR_W-1:0];
                    r_out_ok  <= 1'b1;
                    r_tail    <= tail_w[GW-1:0];
                    r_rest    <= rest;
                end else if (walk_on) begin
                    r_prev      <= r_cur;
                    r_have_prev <= 1'b1;
                    r_cur       <= link_next;
                    r_steps     <= r_steps + GW'(1);
                end else begin
                    r_out_ptr <= '0;
                    r_out_ok  <= 1'b0;
                end
            end
            ST_SPLIT: begin
                r_tail <= r_tail;
            end
            default: begin
                r_cur <= r_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/ffa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- dv/first_fit_free_list_allocator_test.sv -----
// Self-checking testbench for first_fit_free_list_allocator: a heap model predicts every reply.
// Depends on ffa_pkg and the allocator RTL; directed, backpressure, random and cyclic-list tests.
// Stream handshakes on both sides with random idle bursts, one long receiver stall.
`default_nettype none

module first_fit_free_list_allocator_test;
    import ffa_pkg::*;

    localparam int          HEAP_BYTES   = HEAP_BYTES_DEF;
    localparam int          GRANULES     = HEAP_BYTES / 8;
    localparam int          GRAN_W       = $clog2(GRANULES);
    localparam int          BSIZE_W      = SIZE_W + 1;
    localparam int unsigned MIN_BLOCK    = 8;
    localparam int unsigned MIN_SPLIT    = 12;
    localparam int          RANDOM_ITEMS = 1650;
    localparam int          QUIET_TAIL   = 250;
    localparam int          LONG_HOLD    = 200;
    localparam int          DRAIN_CYCLES = 50;

    typedef struct packed {
        logic [PTR_W-1:0] ptr_out;
        logic             ok;
    } t_heap_reply;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // size[15:0], ptr[31:16]
    logic [0:0]  s_axis_tuser  = '0;  // func[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // ptr_out[15:0]
    logic [0:0]  m_axis_tuser;        // ok[0]

    first_fit_free_list_allocator #(.HEAP_BYTES(HEAP_BYTES)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // heap model
    logic [BSIZE_W-1:0] block_size [GRANULES];
    logic [GRAN_W-1:0]  block_next [GRANULES];
    logic               block_next_ok [GRANULES];
    logic [GRAN_W-1:0]  list_head;
    logic               list_head_ok;

    t_heap_reply  pending_replies[$];
    logic [15:0]  live_ptrs[$];
    t_heap_reply  want;
    int           mismatch_count   = 0;
    int           hold_request     = 0;
    int           stall_left       = 0;
    bit           sender_quiet     = 1'b0;
    bit           receiver_quiet   = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_heap_reply apply_heap_op(input logic func, input logic [15:0] size,
                                                  input logic [15:0] ptr);
        t_heap_reply r;
        int unsigned need, cur, prev, rest, tail, steps, g;
        bit          cur_ok, have_prev;
        r.ptr_out = '0;
        r.ok      = 1'b0;
        if (func == FUNC_FREE) begin
            if (ptr == '0) begin
                r.ok = 1'b1;
            end else if (ptr[2:0] == 3'(HDR_BYTES)) begin
                g = (32'(ptr) - HDR_BYTES) >> 3;
                if (g < GRANULES) begin
                    block_next[g]    = list_head;
                    block_next_ok[g] = list_head_ok;
                    list_head        = GRAN_W'(g);
                    list_head_ok     = 1'b1;
                    r.ok             = 1'b1;
                end
            end
            return r;
        end
        need = (((size == '0) ? 32'd1 : 32'(size)) + HDR_BYTES + 7) & ~32'd7;
        if (need < MIN_BLOCK) need = MIN_BLOCK;
        cur       = 32'(list_head);
        cur_ok    = list_head_ok;
        prev      = 0;
        have_prev = 1'b0;
        for (steps = 0; cur_ok && steps < GRANULES; steps++) begin
            if (32'(block_size[cur]) >= need) begin
                if (have_prev) begin
                    block_next[prev]    = block_next[cur];
                    block_next_ok[prev] = block_next_ok[cur];
                end else begin
                    list_head    = block_next[cur];
                    list_head_ok = block_next_ok[cur];
                end
                rest = 32'(block_size[cur]) - need;
                if (rest >= MIN_SPLIT) begin
                    tail = cur + need / 8;
                    if (tail < GRANULES) begin
                        block_size[tail]    = BSIZE_W'(rest);
                        block_next[tail]    = list_head;
                        block_next_ok[tail] = list_head_ok;
                        list_head           = GRAN_W'(tail);
                        list_head_ok        = 1'b1;
                    end
                end
                block_size[cur] = BSIZE_W'(need);
                r.ptr_out       = 16'(cur * 8 + HDR_BYTES);
                r.ok            = 1'b1;
                return r;
            end
            prev      = cur;
            have_prev = 1'b1;
            cur_ok    = block_next_ok[cur];
            cur       = 32'(block_next[cur]);
        end
        return r;
    endfunction

    function automatic logic [15:0] pick_alloc_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, 48));
        if (r < 92) return 16'($urandom_range(49, 1024));
        if (r < 98) return 16'($urandom_range(1025, 8192));
        return 16'($urandom_range(8193, 65535));
    endfunction

    // entered and left just after a falling edge
    task automatic send_item(input logic func, input logic [15:0] size, input logic [15:0] ptr,
                             output t_heap_reply reply);
        int idx[$];
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {ptr, size};
        do @(posedge i_clk); while (!s_axis_tready);
        reply = apply_heap_op(func, size, ptr);
        pending_replies.push_back(reply);
        if (func == FUNC_ALLOC && reply.ok) begin
            live_ptrs.push_back(reply.ptr_out);
        end else if (func == FUNC_FREE) begin
            idx = live_ptrs.find_first_index(x) with (x == ptr);
            if (idx.size() != 0) live_ptrs.delete(idx[0]);
        end
        @(negedge i_clk);
        if (!sender_quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed_extremes();
        t_heap_reply r;
        logic [15:0] a, b, c;
        send_item(FUNC_ALLOC, 16'hFFFF, 16'($urandom), r);
        send_item(FUNC_ALLOC, 16'd65532, 16'($urandom), r);
        a = r.ptr_out;
        send_item(FUNC_ALLOC, 16'd0, 16'($urandom), r);
        send_item(FUNC_FREE, 16'($urandom), 16'd0, r);
        send_item(FUNC_FREE, 16'($urandom), 16'hFFFF, r);
        send_item(FUNC_FREE, 16'($urandom), 16'h0005, r);
        send_item(FUNC_FREE, 16'($urandom), 16'hFFF0, r);
        send_item(FUNC_FREE, 16'($urandom), a, r);
        send_item(FUNC_ALLOC, 16'd65524, 16'($urandom), r);
        a = r.ptr_out;
        send_item(FUNC_FREE, 16'($urandom), a, r);
        send_item(FUNC_ALLOC, 16'd0, 16'($urandom), r);
        a = r.ptr_out;
        send_item(FUNC_ALLOC, 16'd4, 16'($urandom), r);
        b = r.ptr_out;
        send_item(FUNC_ALLOC, 16'd5, 16'($urandom), r);
        c = r.ptr_out;
        send_item(FUNC_ALLOC, 16'h8000, 16'($urandom), r);
        send_item(FUNC_FREE, 16'($urandom), b, r);
        send_item(FUNC_FREE, 16'($urandom), a, r);
        send_item(FUNC_ALLOC, 16'd1, 16'($urandom), r);
        send_item(FUNC_ALLOC, 16'd12, 16'($urandom), r);
        send_item(FUNC_FREE, 16'($urandom), c, r);
        wait_drained();
    endtask

    task automatic test_backpressure();
        t_heap_reply r;
        hold_request = LONG_HOLD;
        repeat (12) begin
            if (live_ptrs.size() != 0 && $urandom_range(0, 2) == 0)
                send_item(FUNC_FREE, 16'($urandom), live_ptrs[0], r);
            else
                send_item(FUNC_ALLOC, pick_alloc_size(), 16'($urandom), r);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic();
        t_heap_reply r;
        int unsigned done_items, roll, pick;
        logic [15:0] p;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            if (done_items >= RANDOM_ITEMS - QUIET_TAIL) begin
                sender_quiet   = 1'b1;
                receiver_quiet = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                p = 16'($urandom);
                if (p[2:0] == 3'(HDR_BYTES)) p[2:0] = 3'($urandom_range(0, 3));
                if (roll == 0) p = '0;
                send_item(FUNC_FREE, 16'($urandom), p, r);
            end else if (live_ptrs.size() == 0 || roll < ((live_ptrs.size() > 48) ? 30 : 58)) begin
                send_item(FUNC_ALLOC, pick_alloc_size(), 16'($urandom), r);
                done_items++;
            end else begin
                pick = $urandom_range(0, live_ptrs.size() - 1);
                send_item(FUNC_FREE, 16'($urandom), live_ptrs[pick], r);
                done_items++;
            end
        end
        wait_drained();
    endtask

    task automatic test_cyclic_list();
        t_heap_reply r;
        logic [15:0] p;
        send_item(FUNC_ALLOC, 16'd4, 16'($urandom), r);
        p = r.ptr_out;
        send_item(FUNC_FREE, 16'($urandom), p, r);
        send_item(FUNC_FREE, 16'($urandom), p, r);
        send_item(FUNC_ALLOC, 16'd4, 16'($urandom), r);
        send_item(FUNC_ALLOC, 16'd300, 16'($urandom), r);
        send_item(FUNC_ALLOC, 16'd4, 16'($urandom), r);
        wait_drained();
    endtask

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!receiver_quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                $error("result with no pending request: ptr_out %0d ok %0d",
                       m_axis_tdata, m_axis_tuser[0]);
                mismatch_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_axis_tdata !== want.ptr_out) begin
                    $error("ptr_out: expected %0d, actual %0d", want.ptr_out, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== want.ok) begin
                    $error("ok: expected %0d, actual %0d", want.ok, m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        for (int g = 0; g < GRANULES; g++) begin
            block_size[g]    = '0;
            block_next[g]    = '0;
            block_next_ok[g] = 1'b0;
        end
        block_size[0] = BSIZE_W'(HEAP_BYTES);
        list_head     = '0;
        list_head_ok  = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_backpressure();
        test_random_traffic();
        test_cyclic_list();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_replies.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/first_fit_free_list_allocator.sv
dv/first_fit_free_list_allocator_test.sv
